// ===== src/nss_pkg.sv =====
// Shared types and constants of the nearest segment search unit.
package nss_pkg;

	localparam int MAX_SEGMENTS_DEF = 1024;
	localparam int MAX_OBJECTS_DEF  = 256;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic       REG_MAX_LEN   = 1'b0;
	localparam logic       REG_OBJ_COUNT = 1'b1;
	localparam logic [22:0] MAX_LEN_RESET = 23'd2048;

	localparam logic [56:0] LIMIT_FLOOR = 57'd65536;
	localparam logic signed [32:0] DOT_MIN = 33'sd67108864;
	localparam logic signed [42:0] ROUND_HALF = 43'sd32768;

	localparam logic [1:0] SEL_START  = 2'd0;
	localparam logic [1:0] SEL_END    = 2'd1;
	localparam logic [1:0] SEL_INTERP = 2'd2;

	typedef struct packed {
		logic signed [23:0] ax;
		logic signed [23:0] ay;
		logic signed [23:0] bx;
		logic signed [23:0] by;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [7:0]         obj;
	} seg_t;

	typedef struct packed {
		logic clear;
		logic append;
		logic load_query;
		logic rd;
		logic diff;
		logic next;
		logic mul;
		logic sum;
		logic sel;
		logic div_step;
		logic off;
		logic close;
		logic sq;
		logic decide;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic query_ok;
		logic scan_done;
		logic tag_match;
		logic interp;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== src/nss_ctrl.sv =====
// Sequencer that walks the segment store for one query at a time.
module nss_ctrl import nss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] kind,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_SUM  = 4'd4;
	localparam logic [3:0] ST_SEL  = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_OFF  = 4'd7;
	localparam logic [3:0] ST_CLS  = 4'd8;
	localparam logic [3:0] ST_SQ   = 4'd9;
	localparam logic [3:0] ST_DEC  = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;

	logic [3:0] state_q, state_d;
	logic       take;

	assign in_ready = (state_q == ST_IDLE) && !sts.out_busy;
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (kind)
						KIND_CLEAR:  cmd.clear = 1'b1;
						KIND_APPEND: cmd.append = 1'b1;
						KIND_QUERY: begin
							cmd.load_query = 1'b1;
							state_d = ST_RD;
						end
						default: ;
					endcase
				end
			end
			ST_RD: begin
				if (!sts.query_ok || sts.scan_done) begin
					state_d = ST_FIN;
				end else begin
					cmd.rd = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				cmd.diff = 1'b1;
				if (sts.tag_match) begin
					state_d = ST_MUL;
				end else begin
					cmd.next = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = sts.interp ? ST_DIV : ST_CLS;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_OFF;
			end
			ST_OFF: begin
				cmd.off = 1'b1;
				state_d = ST_CLS;
			end
			ST_CLS: begin
				cmd.close = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.decide = 1'b1;
				state_d = ST_RD;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== src/nss_dp.sv =====
// Segment store, distance arithmetic, serial divider and result register.
module nss_dp import nss_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int MAX_OBJECTS  = MAX_OBJECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [22:0]        cfg_data,
	input  logic [7:0]         object_tag,
	input  logic signed [23:0] point_ax,
	input  logic signed [23:0] point_ay,
	input  logic signed [23:0] point_bx,
	input  logic signed [23:0] point_by,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [9:0]         segment_index
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = IW + 1;

	seg_t mem [MAX_SEGMENTS];
	seg_t rd_q;

	logic [CW-1:0] count_q, idx_q;
	logic [22:0]   max_len_q;
	logic [8:0]    obj_count_q;
	logic          full;

	logic signed [23:0] px_q, py_q;
	logic signed [15:0] qnx_q, qny_q;
	logic [7:0]         tag_q;
	logic [56:0]        lim_q;
	logic               found_q, out_valid_q;
	logic [IW-1:0]      best_q;
	logic [9:0]         index_q;

	logic signed [24:0] dx_q, dy_q, ex_q, ey_q;
	logic signed [49:0] dx2_q, dy2_q, exdx_q, eydy_q;
	logic signed [31:0] dotx_q, doty_q;
	logic signed [51:0] num_q, len2_q;
	logic signed [32:0] dot_q;
	logic [1:0]         mode_q;
	logic [51:0]        rem_q;
	logic [15:0]        quo_q;
	logic [3:0]         cnt_q;
	logic signed [26:0] offx_q, offy_q;
	logic signed [27:0] ux_q, uy_q;
	logic [55:0]        sqx_q, sqy_q;

	logic [51:0]        len2_sum, rem_sh;
	logic signed [51:0] num_sum;
	logic signed [42:0] prx, pry;
	logic signed [27:0] cx, cy;
	logic [56:0]        d2;
	logic [45:0]        len_sq;
	logic [IW+9:0]      best_ext;

	function automatic logic [IW-1:0] idx_fix(input logic [CW-1:0] v);
		idx_fix = v[IW-1:0];
	endfunction

	assign full = (count_q >= CW'(MAX_SEGMENTS));

	// Segment store write and entry read register
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem[idx_fix(count_q)] <= '{ax: point_ax, ay: point_ay, bx: point_bx, by: point_by,
				nx: normal_x, ny: normal_y, obj: object_tag};
		end
		if (cmd.rd) rd_q <= mem[idx_fix(idx_q)];
	end

	assign len_sq = {23'd0, max_len_q} * {23'd0, max_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			max_len_q   <= MAX_LEN_RESET;
			obj_count_q <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_LEN) max_len_q <= cfg_data;
				else                          obj_count_q <= cfg_data[8:0];
			end
			if (cmd.clear) count_q <= '0;
			if (cmd.append && !full) count_q <= count_q + 1'b1;
			if (cmd.load_query) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.next) idx_q <= idx_q + 1'b1;
			if (cmd.decide) begin
				idx_q <= idx_q + 1'b1;
				if (d2 <= lim_q && dot_q >= DOT_MIN) found_q <= 1'b1;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.finish) out_valid_q <= 1'b1;
		end
	end

	assign len2_sum = 52'(dx2_q + dy2_q);
	assign num_sum  = 52'(exdx_q) + 52'(eydy_q);
	assign rem_sh   = {rem_q[50:0], 1'b0};
	assign prx      = 43'(dx_q) * $signed({27'd0, quo_q});
	assign pry      = 43'(dy_q) * $signed({27'd0, quo_q});
	assign d2       = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign best_ext = {10'd0, best_q};

	always_comb begin
		case (mode_q)
			SEL_START: begin
				cx = 28'(rd_q.ax);
				cy = 28'(rd_q.ay);
			end
			SEL_END: begin
				cx = 28'(rd_q.bx);
				cy = 28'(rd_q.by);
			end
			default: begin
				cx = 28'(rd_q.ax) + 28'(offx_q);
				cy = 28'(rd_q.ay) + 28'(offy_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			px_q  <= point_ax;
			py_q  <= point_ay;
			qnx_q <= normal_x;
			qny_q <= normal_y;
			tag_q <= object_tag;
			best_q <= '0;
			lim_q <= (57'(len_sq) < LIMIT_FLOOR) ? LIMIT_FLOOR : 57'(len_sq);
		end
		if (cmd.diff) begin
			dx_q <= 25'(rd_q.bx) - 25'(rd_q.ax);
			dy_q <= 25'(rd_q.by) - 25'(rd_q.ay);
			ex_q <= 25'(px_q) - 25'(rd_q.ax);
			ey_q <= 25'(py_q) - 25'(rd_q.ay);
		end
		if (cmd.mul) begin
			dx2_q  <= dx_q * dx_q;
			dy2_q  <= dy_q * dy_q;
			exdx_q <= ex_q * dx_q;
			eydy_q <= ey_q * dy_q;
			dotx_q <= rd_q.nx * qnx_q;
			doty_q <= rd_q.ny * qny_q;
		end
		if (cmd.sum) begin
			num_q  <= num_sum;
			len2_q <= (len2_sum == '0) ? 52'sd1 : $signed(len2_sum);
			dot_q  <= 33'(dotx_q) + 33'(doty_q);
		end
		if (cmd.sel) begin
			rem_q <= num_q;
			quo_q <= '0;
			cnt_q <= '0;
			if (num_q <= 0)           mode_q <= SEL_START;
			else if (num_q >= len2_q) mode_q <= SEL_END;
			else                      mode_q <= SEL_INTERP;
		end
		// One quotient bit a cycle
		if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (rem_sh >= len2_q) begin
				rem_q <= rem_sh - len2_q;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.off) begin
			offx_q <= 27'((prx + ROUND_HALF) >>> 16);
			offy_q <= 27'((pry + ROUND_HALF) >>> 16);
		end
		if (cmd.close) begin
			ux_q <= 28'(px_q) - cx;
			uy_q <= 28'(py_q) - cy;
		end
		if (cmd.sq) begin
			sqx_q <= 56'(ux_q * ux_q);
			sqy_q <= 56'(uy_q * uy_q);
		end
		if (cmd.decide && d2 <= lim_q && dot_q >= DOT_MIN) begin
			lim_q  <= d2;
			best_q <= idx_fix(idx_q);
		end
		if (cmd.finish) index_q <= found_q ? best_ext[9:0] : 10'd0;
	end

	assign sts.query_ok  = ({1'b0, tag_q} < obj_count_q) && (32'(tag_q) < 32'(MAX_OBJECTS));
	assign sts.scan_done = (idx_q >= count_q);
	assign sts.tag_match = (rd_q.obj == tag_q);
	assign sts.interp    = (num_q > 0) && (num_q < len2_q);
	assign sts.div_last  = (cnt_q == 4'd15);
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign segment_index = index_q;

endmodule

// ===== src/nearest_segment_search_unit.sv =====
// Top level of the nearest segment search unit.
// Items arrive on in_valid/in_ready: kind 0 empties the segment store, kind 1
// appends a segment (dropped once the store holds MAX_SEGMENTS), kind 2 asks
// for the nearest segment of an object, kind 3 is dropped. Only queries give a
// result, on out_valid/out_ready as found and segment_index.
// A query whose tag is below the object count and MAX_OBJECTS walks the whole
// store, one entry at a time through a shared sequencer: an entry of another
// object is only read and checked; a matching one goes through multiply, sum,
// select, the 16-bit restoring divider when the projection is interior, closest
// point, square and decide.
// The result waits in an output register; no new item is taken while it is
// held and the receiver stalls. Configuration (cfg_valid/cfg_ready, cfg_index,
// cfg_data) is always ready; write it only while the block is idle.
// Reset empties the store, drops any pending result and loads the register
// reset values. Store contents are undefined until written.
module nearest_segment_search_unit import nss_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int MAX_OBJECTS  = MAX_OBJECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [22:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [7:0]         object_tag,
	input  logic signed [23:0] point_ax,
	input  logic signed [23:0] point_ay,
	input  logic signed [23:0] point_bx,
	input  logic signed [23:0] point_by,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [9:0]         segment_index
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	nss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nss_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.MAX_OBJECTS  (MAX_OBJECTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.object_tag    (object_tag),
		.point_ax      (point_ax),
		.point_ay      (point_ay),
		.point_bx      (point_bx),
		.point_by      (point_by),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.segment_index (segment_index)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the nearest segment search unit.
`timescale 1ns / 100ps

module tb_top;
	import nss_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STORE_DEPTH = 1024;
	localparam int OBJ_LIMIT = 256;
	localparam int STALL_LIMIT = 200000;
	localparam longint DOT_FLOOR = 64'sd67108864;
	localparam longint LIMIT_MIN = 64'sd65536;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] tag;
		logic signed [23:0] ax, ay, bx, by;
		logic signed [15:0] nx, ny;
	} item_t;

	typedef struct {
		logic hit;
		logic [9:0] idx;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_ready, cfg_index = 1'b0;
	logic [22:0] cfg_data = '0;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] kind = '0;
	logic [7:0] object_tag = '0;
	logic signed [23:0] point_ax = '0, point_ay = '0, point_bx = '0, point_by = '0;
	logic signed [15:0] normal_x = '0, normal_y = '0;
	logic out_valid, out_ready = 1'b0, found;
	logic [9:0] segment_index;

	nearest_segment_search_unit dut (.*);

	initial forever #5 clk = ~clk;

	// model of the store and registers
	longint seg_sx[STORE_DEPTH], seg_sy[STORE_DEPTH], seg_ex[STORE_DEPTH];
	longint seg_ey[STORE_DEPTH], seg_nx[STORE_DEPTH], seg_ny[STORE_DEPTH];
	logic [7:0] seg_tag[STORE_DEPTH];
	int stored_count = 0;
	longint max_len = 2048, obj_count = 0;

	item_t pending_items[$];
	match_t expected_matches[$];
	int errors = 0, in_gap = 0, out_gap = 0, quiet_cycles = 0;
	logic quiet = 1'b0, in_taken = 1'b0;

	// generator bookkeeping
	int gen_fill = 0;
	logic signed [23:0] recent_x[8], recent_y[8];

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic longint dist_sq(input int i, input longint px, input longint py);
		longint dx, dy, len2, num, cx, cy, r, q;
		dx = seg_ex[i] - seg_sx[i];
		dy = seg_ey[i] - seg_sy[i];
		len2 = dx * dx + dy * dy;
		num = (px - seg_sx[i]) * dx + (py - seg_sy[i]) * dy;
		if (len2 < 1) len2 = 1;
		if (num <= 0) begin
			cx = seg_sx[i];
			cy = seg_sy[i];
		end else if (num >= len2) begin
			cx = seg_ex[i];
			cy = seg_ey[i];
		end else begin
			r = num;
			q = 0;
			for (int k = 0; k < 16; k++) begin
				r = r <<< 1;
				q = q <<< 1;
				if (r >= len2) begin
					r -= len2;
					q |= 1;
				end
			end
			cx = seg_sx[i] + ((dx * q + 32768) >>> 16);
			cy = seg_sy[i] + ((dy * q + 32768) >>> 16);
		end
		cx = px - cx;
		cy = py - cy;
		return cx * cx + cy * cy;
	endfunction

	function automatic match_t nearest_match(input item_t it);
		match_t m;
		longint lim, d2, dot;
		m.hit = 1'b0;
		m.idx = '0;
		if (it.tag < obj_count && it.tag < OBJ_LIMIT) begin
			lim = max_len * max_len;
			if (lim < LIMIT_MIN) lim = LIMIT_MIN;
			for (int i = 0; i < stored_count; i++) begin
				if (seg_tag[i] == it.tag) begin
					d2 = dist_sq(i, it.ax, it.ay);
					dot = seg_nx[i] * it.nx + seg_ny[i] * it.ny;
					if (d2 <= lim && dot >= DOT_FLOOR) begin
						lim = d2;
						m.hit = 1'b1;
						m.idx = i[9:0];
					end
				end
			end
		end
		return m;
	endfunction

	task automatic apply_item(input item_t it);
		case (it.kind)
			KIND_CLEAR: stored_count = 0;
			KIND_APPEND: if (stored_count < STORE_DEPTH) begin
				seg_sx[stored_count] = it.ax;
				seg_sy[stored_count] = it.ay;
				seg_ex[stored_count] = it.bx;
				seg_ey[stored_count] = it.by;
				seg_nx[stored_count] = it.nx;
				seg_ny[stored_count] = it.ny;
				seg_tag[stored_count] = it.tag;
				stored_count++;
			end
			KIND_QUERY: expected_matches.push_back(nearest_match(it));
			default: ;
		endcase
	endtask

	// monitor, predictor update and watchdog
	always @(posedge clk) begin
		item_t it;
		match_t m;
		logic busy;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			busy = 1'b0;
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				if (cfg_index == REG_MAX_LEN) max_len = cfg_data;
				else obj_count = cfg_data[8:0];
			end
			if (in_valid && in_ready) begin
				busy = 1'b1;
				it.kind = kind; it.tag = object_tag;
				it.ax = point_ax; it.ay = point_ay; it.bx = point_bx; it.by = point_by;
				it.nx = normal_x; it.ny = normal_y;
				apply_item(it);
			end
			if (out_valid && out_ready) begin
				busy = 1'b1;
				if (expected_matches.size() == 0) report("result with no query waiting");
				else begin
					m = expected_matches.pop_front();
					if (found !== m.hit)
						report($sformatf("found %0b, want %0b", found, m.hit));
					if (segment_index !== m.idx)
						report($sformatf("segment_index %0d, want %0d", segment_index, m.idx));
				end
			end
			quiet_cycles <= busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("nearest_segment_search_unit verification failed");
				$finish;
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		item_t it;
		logic nv;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				nv = 1'b0;
				if (in_gap > 0) in_gap <= in_gap - 1;
				else if (pending_items.size() != 0) begin
					if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(0, 13);
					else begin
						it = pending_items.pop_front();
						nv = 1'b1;
						kind <= it.kind; object_tag <= it.tag;
						point_ax <= it.ax; point_ay <= it.ay;
						point_bx <= it.bx; point_by <= it.by;
						normal_x <= it.nx; normal_y <= it.ny;
					end
				end
				in_valid <= nv;
			end
			// receiver stalls
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_gap <= $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic idx, input logic [22:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		wait (pending_items.size() == 0 && !in_valid && expected_matches.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic item_t make_item(input logic [1:0] k, input logic [7:0] t,
			input int ax, input int ay, input int bx, input int by,
			input int nx, input int ny);
		item_t it;
		it.kind = k; it.tag = t;
		it.ax = 24'(ax); it.ay = 24'(ay); it.bx = 24'(bx); it.by = 24'(by);
		it.nx = 16'(nx); it.ny = 16'(ny);
		return it;
	endfunction

	function automatic int near_normal();
		return $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 65535)) - 32768
			: int'($urandom_range(0, 20000)) - 2000;
	endfunction

	// segment near the origin, sometimes degenerate, with occasional wild coordinates
	task automatic add_segment(input logic [7:0] t);
		item_t it;
		int ax, ay;
		ax = int'($urandom_range(0, 6000)) - 3000;
		ay = int'($urandom_range(0, 6000)) - 3000;
		it = make_item(KIND_APPEND, t, ax, ay,
			ax + int'($urandom_range(0, 3000)) - 1500,
			ay + int'($urandom_range(0, 3000)) - 1500, near_normal(), near_normal());
		if ($urandom_range(0, 9) == 0) begin
			it.bx = it.ax;
			it.by = it.ay;
		end
		if ($urandom_range(0, 14) == 0) begin
			it.ax = 24'($urandom); it.ay = 24'($urandom);
			it.bx = 24'($urandom); it.by = 24'($urandom);
		end
		recent_x[gen_fill % 8] = it.ax;
		recent_y[gen_fill % 8] = it.ay;
		gen_fill++;
		pending_items.push_back(it);
	endtask

	task automatic add_query(input logic [7:0] t);
		item_t it;
		int j;
		j = $urandom_range(0, 7);
		it = make_item(KIND_QUERY, t, int'($urandom_range(0, 6000)) - 3000,
			int'($urandom_range(0, 6000)) - 3000, $urandom, $urandom,
			near_normal(), near_normal());
		// aim near a recent segment start, sometimes at its exact x
		if (gen_fill > 0 && $urandom_range(0, 1) == 0) begin
			it.ax = 24'(recent_x[j] + ($urandom_range(0, 2) == 0 ? 0
				: int'($urandom_range(0, 1200)) - 600));
			it.ay = 24'(recent_y[j] + int'($urandom_range(0, 600)) - 300);
		end
		if ($urandom_range(0, 14) == 0) begin
			it.ax = 24'($urandom); it.ay = 24'($urandom);
		end
		pending_items.push_back(it);
	endtask

	task automatic random_phase(input int n, input int tags);
		item_t it;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5 || gen_fill > 60) begin
				pending_items.push_back(make_item(KIND_CLEAR, 8'($urandom), $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom));
				gen_fill = 0;
			end else if (r < 50) add_segment(8'($urandom_range(0, tags - 1)));
			else if (r < 92) add_query($urandom_range(0, 9) == 0 ? 8'($urandom)
				: 8'($urandom_range(0, tags - 1)));
			else begin
				// noise: any kind, any field value
				it = make_item(2'($urandom), 8'($urandom), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				if (it.kind == KIND_CLEAR) gen_fill = 0;
				if (it.kind == KIND_APPEND) gen_fill++;
				pending_items.push_back(it);
			end
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// object_count still zero: every query finds nothing
		pending_items.push_back(make_item(KIND_APPEND, 8'd0, 0, 0, 512, 0, 16384, 0));
		pending_items.push_back(make_item(KIND_QUERY, 8'd0, 0, 0, 0, 0, 16384, 0));
		drain();
		write_reg(REG_OBJ_COUNT, 23'd256);

		// directed: extremes, degenerate segment, normal threshold, unused kind
		pending_items.push_back(make_item(KIND_CLEAR, 8'd0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(KIND_APPEND, 8'd255, -8388608, -8388608,
			8388607, 8388607, -32768, -32768));
		pending_items.push_back(make_item(KIND_APPEND, 8'd255, 8388607, -8388608,
			-8388608, 8388607, 32767, 32767));
		pending_items.push_back(make_item(KIND_APPEND, 8'd7, 100, 100, 100, 100, 16384, 0));
		pending_items.push_back(make_item(KIND_APPEND, 8'd7, 0, 0, 1000, 0, 0, 16384));
		pending_items.push_back(make_item(KIND_APPEND, 8'd7, 0, 0, 1000, 0, 4096, 0));
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, 100, 100, 0, 0, 16384, 0));
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, 500, 300, 0, 0, 16384, 16384));
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, 500, 0, 0, 0, 16383, 0));
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, -400, 7, 0, 0, 4096, 4096));
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, 1300, -9, 0, 0, 4096, 4096));
		pending_items.push_back(make_item(KIND_QUERY, 8'd255, -8388608, -8388608,
			-1, -1, -32768, -32768));
		pending_items.push_back(make_item(KIND_QUERY, 8'd255, 8388607, 8388607,
			0, 0, 32767, 32767));
		pending_items.push_back(make_item(KIND_UNUSED, 8'd7, 100, 100, 0, 0, 16384, 0));
		pending_items.push_back(make_item(KIND_QUERY, 8'd9, 0, 0, 0, 0, 16384, 0));
		drain();

		write_reg(REG_MAX_LEN, 23'd0);
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, 100, 356, 0, 0, 16384, 0));
		pending_items.push_back(make_item(KIND_QUERY, 8'd7, 100, 357, 0, 0, 16384, 0));
		drain();

		write_reg(REG_MAX_LEN, 23'd2048);
		random_phase(150, 4);
		write_reg(REG_MAX_LEN, 23'd8388607);
		write_reg(REG_OBJ_COUNT, 23'd3);
		random_phase(130, 5);
		write_reg(REG_MAX_LEN, 23'd1);
		write_reg(REG_OBJ_COUNT, 23'd200);
		random_phase(110, 3);
		write_reg(REG_MAX_LEN, 23'd700);
		write_reg(REG_OBJ_COUNT, 23'd256);
		random_phase(130, 4);

		// back to back with no idling to the end
		quiet = 1'b1;
		pending_items.push_back(make_item(KIND_CLEAR, 8'd0, 0, 0, 0, 0, 0, 0));
		gen_fill = 0;
		for (int i = 0; i < 30; i++) add_segment(8'($urandom_range(0, 2)));
		pending_items.push_back(make_item(KIND_QUERY, 8'd1, recent_x[0], recent_y[0],
			0, 0, 16384, 0));
		for (int i = 0; i < 3; i++) add_query(8'($urandom_range(0, 2)));
		drain();

		if (errors == 0)
			$display("nearest_segment_search_unit verification clean");
		else
			$display("nearest_segment_search_unit verification failed");
		$finish;
	end

endmodule
